### hw/rtl/mbid_pkg.sv
// shared types and constants for the multi-button debounce block
`default_nettype none
package mbid_pkg;

	localparam int CMD_W = 2;
	localparam int RAW_W = 8;
	localparam int IDX_W = 8;
	localparam int INTEG_W = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_SCAN    = 2'd0,
		CMD_HELD    = 2'd1,
		CMD_PRESSED = 2'd2
	} cmd_t;

	localparam logic [INTEG_W-1:0] THRESHOLD_RESET = 4'd4;
	localparam logic REG_THRESHOLD = 1'b0;

	// per-lane control for one cycle
	typedef struct packed {
		logic               scan;
		logic               level;
		logic               clr_latch;
		logic [INTEG_W-1:0] thr;
	} lane_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/mbid_lane.sv
// one button: saturating integrator, held bit and sticky pressed latch
`default_nettype none
module mbid_lane (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mbid_pkg::lane_ctl_t ctl,
	output logic                   held,
	output logic                   latch
);
	import mbid_pkg::*;

	logic [INTEG_W-1:0] integ_q;
	logic [INTEG_W-1:0] integ_d;
	logic               held_q;
	logic               latch_q;
	logic               held_d;
	logic               latch_d;

	always_comb begin
		integ_d = integ_q;
		held_d = held_q;
		latch_d = latch_q;
		if (ctl.scan) begin
			if (ctl.level) begin
				if (integ_q < ctl.thr) begin
					integ_d = integ_q + INTEG_W'(1);
				end
			end else if (integ_q != '0) begin
				integ_d = integ_q - INTEG_W'(1);
			end
			// threshold match wins over zero when threshold is zero
			if (integ_d == ctl.thr) begin
				if (!held_q) begin
					held_d = 1'b1;
					latch_d = 1'b1;
				end
			end else if (integ_d == '0) begin
				held_d = 1'b0;
			end
		end
		if (ctl.clr_latch) begin
			latch_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			held_q <= 1'b0;
			latch_q <= 1'b0;
		end else begin
			integ_q <= integ_d;
			held_q <= held_d;
			latch_q <= latch_d;
		end
	end

	assign held = held_q;
	assign latch = latch_q;

endmodule
`default_nettype wire

### hw/rtl/multi_button_integrator_debounce_top.sv
// top level: input register, button lanes, query select and result register
// result path: an accepted query word passes the input register, then the result register
// throughput: one word per cycle while req_stall is low; set by the single input register stage
// scan words update all lanes in parallel and give no result
// reset: integrators, held bits, pressed latches cleared; threshold set to 4
`default_nettype none
module multi_button_integrator_debounce_top #(
	parameter int BUTTON_COUNT = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  wire logic                         req_valid,
	output logic                              req_stall,
	input  wire logic [mbid_pkg::CMD_W-1:0]   cmd,
	input  wire logic [mbid_pkg::RAW_W-1:0]   raw_levels,
	input  wire logic [mbid_pkg::IDX_W-1:0]   button_index,
	output logic                              rsp_valid,
	input  wire logic                         rsp_stall,
	output logic                              answer,
	output logic                              index_ok
);
	import mbid_pkg::*;

	localparam int SEL_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int PAD_N = 1 << SEL_W;

	// configuration register
	logic [INTEG_W-1:0] thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD) begin
			thr_q <= pwdata[INTEG_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESHOLD) ? {{(32-INTEG_W){1'b0}}, thr_q} : 32'd0;

	// input register stage
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [RAW_W-1:0]  raw_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              is_scan;
	logic              is_query;
	logic              is_pressed;
	logic              adv_s1;
	logic              load_out;
	logic              take_in;

	always_comb begin
		is_scan = 1'b0;
		is_query = 1'b0;
		is_pressed = 1'b0;
		case (cmd_s1)
			CMD_SCAN: begin
				is_scan = 1'b1;
			end
			CMD_HELD: begin
				is_query = 1'b1;
			end
			CMD_PRESSED: begin
				is_query = 1'b1;
				is_pressed = 1'b1;
			end
			default: begin
				is_scan = 1'b0;
			end
		endcase
	end

	// a word with no result always moves on; a query needs the result slot
	assign adv_s1 = valid_s1 && (!is_query || !rsp_valid || !rsp_stall);
	assign load_out = adv_s1 && is_query;
	assign req_stall = valid_s1 && !adv_s1;
	assign take_in = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1 <= cmd;
			raw_s1 <= raw_levels;
			idx_s1 <= button_index;
		end
	end

	// query decode
	logic ok_s1;
	logic [SEL_W-1:0] sel_s1;

	assign ok_s1 = (idx_s1 < IDX_W'(BUTTON_COUNT));
	assign sel_s1 = idx_s1[SEL_W-1:0];

	// button lanes
	logic [PAD_N-1:0] held_vec;
	logic [PAD_N-1:0] latch_vec;

	genvar gi;
	generate
		for (gi = 0; gi < PAD_N; gi++) begin : g_lane
			if (gi < BUTTON_COUNT) begin : g_real
				lane_ctl_t ctl;
				always_comb begin
					ctl.scan = adv_s1 && is_scan;
					ctl.level = (gi < RAW_W) ? raw_s1[gi % RAW_W] : 1'b0;
					ctl.clr_latch = adv_s1 && is_pressed && ok_s1 &&
						(sel_s1 == SEL_W'(gi));
					ctl.thr = thr_q;
				end
				mbid_lane u_lane (
					.clk    (clk),
					.arst_n (arst_n),
					.ctl    (ctl),
					.held   (held_vec[gi]),
					.latch  (latch_vec[gi])
				);
			end else begin : g_pad
				assign held_vec[gi] = 1'b0;
				assign latch_vec[gi] = 1'b0;
			end
		end
	endgenerate

	// result register
	logic answer_d;
	logic rsp_valid_q;
	logic answer_q;
	logic index_ok_q;

	assign answer_d = ok_s1 && (is_pressed ? latch_vec[sel_s1] : held_vec[sel_s1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			answer_q <= answer_d;
			index_ok_q <= ok_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign answer = answer_q;
	assign index_ok = index_ok_q;

	// a stalled result word is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |-> !load_out)
		else $error("result word overwritten while stalled");

	// stall only comes from a word waiting in the input stage
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && is_query && rsp_valid_q && rsp_stall))
		else $error("input stalled without a blocked query");

	// an out-of-range query never answers true
	a_bad_index: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !index_ok_q) |-> !answer_q)
		else $error("answer set for an invalid index");

	// a pressed query clears the latch it read
	a_latch_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && is_pressed && ok_s1) |=> !latch_vec[$past(sel_s1)])
		else $error("pressed latch not cleared by query");

endmodule
`default_nettype wire
